>>> sv/tmt_pkg.sv
// Shared types and constants for the TinyMT32 generator.
package tmt_pkg;

   typedef logic [31:0] word_type;
   typedef logic [2:0]  round_type;

   // Input item action codes
   localparam logic ActNext   = 1'b0;
   localparam logic ActReseed = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CsrMaskA  = 2'd0;
   localparam logic [1:0] CsrMaskB  = 2'd1;
   localparam logic [1:0] CsrTemper = 2'd2;

   localparam word_type MaskAReset  = 32'h8F70_11EE;
   localparam word_type MaskBReset  = 32'hFC78_FF1F;
   localparam word_type TemperReset = 32'h3793_FDFF;

   localparam word_type MixMul = 32'd1812433253;
   localparam word_type Low31  = 32'h7FFF_FFFF;
   localparam int       MixShift = 30;
   localparam int       AdvShift = 10;
   localparam int       TmpShift = 8;

   // Fallback state for a degenerate seed: 'T','I','N','Y'
   localparam word_type CharT = 32'h0000_0054;
   localparam word_type CharI = 32'h0000_0049;
   localparam word_type CharN = 32'h0000_004E;
   localparam word_type CharY = 32'h0000_0059;

   localparam round_type MixFirst = 3'd1;
   localparam round_type MixLast  = 3'd7;
   localparam round_type AdvFirst = 3'd0;
   localparam round_type AdvLast  = 3'd7;

   typedef struct packed {
      logic      load;     // load seed and masks into the state
      logic      mix;      // one seeding round
      logic      fix;      // realign words, check for degenerate state
      logic      advance;  // one state advance
      logic      emit;     // capture tempered value of the advanced state
      round_type round;
   } tmt_cmd_type;

endpackage

>>> sv/tmt_channels.sv
// Request and response channel interfaces for the TinyMT32 generator.
interface tmt_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] seed;

   modport source (output valid, action, seed, input ready);
   modport sink   (input valid, action, seed, output ready);
endinterface

interface tmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_value;

   modport source (output valid, random_value, input ready);
   modport sink   (input valid, random_value, output ready);
endinterface

>>> sv/tinymt32_generator.sv
// TinyMT32 generator top level: sequencer, datapath and checks.
// A next beat (action 0) advances the 127-bit state and yields one tempered
// 32-bit value; advance and tempering complete in the accept cycle, so one
// value per clock is sustained as long as the response side keeps taking
// beats. A reseed beat (action 1) yields no response and keeps the request
// side closed through 7 seeding rounds through the single 32x32 multiplier,
// one word realignment and degenerate-state check, then 8 state advances.
// Mask registers written over the csr port act on the next advance or reseed;
// write them only while the block is idle.
module tinymt32_generator
   import tmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tmt_req_if.sink     req_ch,
   tmt_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  word_type    csr_wdata
);

   tmt_cmd_type cmd;
   logic        req_ready;
   logic        rsp_valid;
   logic        req_fire;

   tmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .rsp_ready  (rsp_ch.ready),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   tmt_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .seed         (req_ch.seed),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .random_value (rsp_ch.random_value)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign req_fire     = req_ch.valid && req_ready;

   // A reseed closes the request side right away
   a_reseed_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_ch.action == ActReseed) |=> !req_ready)
      else $error("request accepted right after a reseed beat");

   // and keeps it closed through the last pre-advance
   a_reseed_len: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_ch.action == ActReseed) |-> ##16 !req_ready)
      else $error("reseed sequence ended early");

   // A response only appears after a next beat
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_fire && (req_ch.action == ActNext)))
      else $error("response beat without a next request");

   // Reseed steps never issue a response capture
   a_no_emit_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.mix || cmd.fix) |-> !cmd.emit && !req_ready)
      else $error("capture or accept during reseed");

endmodule

>>> sv/tmt_ctrl.sv
// Sequencer for the TinyMT32 generator: handshakes and reseed step control.
module tmt_ctrl
   import tmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_action,
   input  logic        rsp_ready,
   output logic        req_ready,
   output logic        rsp_valid,
   output tmt_cmd_type cmd
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StMix  = 2'd1;
   localparam logic [1:0] StFix  = 2'd2;
   localparam logic [1:0] StAdv  = 2'd3;

   logic [1:0] state_ff, state_in;
   round_type  round_ff, round_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire;

   assign req_ready = (state_ff == StIdle) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      cmd          = '0;
      cmd.round    = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         StIdle: begin
            if (req_fire) begin
               if (req_action == ActReseed) begin
                  cmd.load = 1'b1;
                  state_in = StMix;
                  round_in = MixFirst;
               end else begin
                  cmd.advance  = 1'b1;
                  cmd.emit     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         StMix: begin
            cmd.mix = 1'b1;
            if (round_ff == MixLast) begin
               state_in = StFix;
            end else begin
               round_in = round_ff + 3'd1;
            end
         end
         StFix: begin
            cmd.fix  = 1'b1;
            state_in = StAdv;
            round_in = AdvFirst;
         end
         StAdv: begin
            cmd.advance = 1'b1;
            if (round_ff == AdvLast) begin
               state_in = StIdle;
            end else begin
               round_in = round_ff + 3'd1;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/tmt_dp.sv
// Datapath for the TinyMT32 generator: state words, masks, mixer, advance, tempering.
module tmt_dp
   import tmt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tmt_cmd_type cmd,
   input  word_type    seed,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  word_type    csr_wdata,
   output word_type    random_value
);

   word_type mask_a_ff, mask_b_ff, temper_ff;
   word_type w_ff [4];
   word_type w_in [4];
   word_type out_ff;

   word_type adv_x, adv_y, adv_fb;
   word_type adv [4];
   word_type rot [4];
   word_type mix_p, mix_prod;
   word_type tmp_sum, tmp_val;
   logic     degenerate;

   // State advance
   always_comb begin
      adv_x  = (w_ff[0] & Low31) ^ w_ff[1] ^ w_ff[2];
      adv_x  = adv_x ^ (adv_x << 1);
      adv_y  = w_ff[3] ^ (w_ff[3] >> 1) ^ adv_x;
      adv_fb = {32{adv_y[0]}};
      adv[0] = w_ff[1];
      adv[1] = w_ff[2] ^ (adv_fb & mask_a_ff);
      adv[2] = adv_x ^ (adv_y << AdvShift) ^ (adv_fb & mask_b_ff);
      adv[3] = adv_y;
   end

   // Tempering of the advanced state
   always_comb begin
      tmp_sum = adv[0] + (adv[2] >> TmpShift);
      tmp_val = adv[3] ^ tmp_sum ^ ({32{tmp_sum[0]}} & temper_ff);
   end

   // Seeding rounds run on a rotating window: word 0 feeds, word 1 is updated,
   // then all four rotate down by one. Seven rounds plus the fix step make
   // eight rotations, which restores the original word order.
   always_comb begin
      mix_p    = w_ff[0] ^ (w_ff[0] >> MixShift);
      mix_prod = mix_p * MixMul;
   end

   always_comb begin
      rot[0] = w_ff[1];
      rot[1] = w_ff[2];
      rot[2] = w_ff[3];
      rot[3] = w_ff[0];
      degenerate = ((rot[0] & Low31) == '0) && (rot[1] == '0) &&
                   (rot[2] == '0) && (rot[3] == '0);
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         w_in[k] = w_ff[k];
      end
      if (cmd.load) begin
         w_in[0] = seed;
         w_in[1] = mask_a_ff;
         w_in[2] = mask_b_ff;
         w_in[3] = temper_ff;
      end else if (cmd.mix) begin
         w_in[0] = w_ff[1] ^ (mix_prod + {29'd0, cmd.round});
         w_in[1] = w_ff[2];
         w_in[2] = w_ff[3];
         w_in[3] = w_ff[0];
      end else if (cmd.fix) begin
         if (degenerate) begin
            w_in[0] = CharT;
            w_in[1] = CharI;
            w_in[2] = CharN;
            w_in[3] = CharY;
         end else begin
            for (int k = 0; k < 4; k++) begin
               w_in[k] = rot[k];
            end
         end
      end else if (cmd.advance) begin
         for (int k = 0; k < 4; k++) begin
            w_in[k] = adv[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            w_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < 4; k++) begin
            w_ff[k] <= w_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_a_ff <= MaskAReset;
         mask_b_ff <= MaskBReset;
         temper_ff <= TemperReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrMaskA:  mask_a_ff <= csr_wdata;
            CsrMaskB:  mask_b_ff <= csr_wdata;
            CsrTemper: temper_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff <= tmp_val;
      end
   end

   assign random_value = out_ff;

endmodule

>>> tb/tinymt32_generator_tb.sv
// Self-checking testbench for the TinyMT32 generator: random traffic, mask phases, predictor.
`timescale 1ns / 100ps

module tinymt32_generator_tb;
   import tmt_pkg::*;

   localparam logic [1:0] CsrUnused    = 2'd3;  // no register behind this index
   localparam int         SettleCycles = 24;    // covers the reseed busy window
   localparam int         ReportLimit  = 10;

   typedef struct packed {
      logic     action;
      word_type seed;
   } request_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = 2'd0;
   word_type   csr_wdata = '0;

   tmt_req_if req_ch ();
   tmt_rsp_if rsp_ch ();

   tinymt32_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // predictor copy of the generator
   word_type gen_state [4];
   word_type mask_a = MaskAReset;
   word_type mask_b = MaskBReset;
   word_type mask_t = TemperReset;

   request_beat_type pending_requests [$];
   word_type         expected_values [$];
   int               queued_total = 0;
   int               accepted_total = 0;
   int               error_count = 0;

   request_beat_type next_req;
   int               send_gap = 0;
   int               send_calm = 0;
   int               recv_hold = 0;
   int               recv_calm = 0;

   function automatic word_type mix_term(word_type p, word_type round_no);
      return round_no + MixMul * (p ^ (p >> MixShift));
   endfunction

   function automatic void advance_state();
      word_type x, y, fb;
      x = (gen_state[0] & Low31) ^ gen_state[1] ^ gen_state[2];
      y = gen_state[3];
      x ^= x << 1;
      y ^= (y >> 1) ^ x;
      fb = {32{y[0]}};
      gen_state[0] = gen_state[1];
      gen_state[1] = gen_state[2] ^ (fb & mask_a);
      gen_state[2] = x ^ (y << AdvShift) ^ (fb & mask_b);
      gen_state[3] = y;
   endfunction

   function automatic word_type tempered_value();
      word_type t1, t0;
      t1 = gen_state[0] + (gen_state[2] >> TmpShift);
      t0 = gen_state[3] ^ t1;
      if (t1[0]) t0 ^= mask_t;
      return t0;
   endfunction

   function automatic void reseed_state(word_type s);
      word_type p;
      int       i;
      gen_state[0] = s;
      gen_state[1] = mask_a;
      gen_state[2] = mask_b;
      gen_state[3] = mask_t;
      for (i = 1; i < 8; i++) begin
         p = gen_state[(i - 1) & 3];
         gen_state[i & 3] ^= mix_term(p, word_type'(i));
      end
      // degenerate state falls back to the fixed TINY pattern
      if ((gen_state[0] & Low31) == '0 && gen_state[1] == '0 &&
          gen_state[2] == '0 && gen_state[3] == '0) begin
         gen_state[0] = CharT;
         gen_state[1] = CharI;
         gen_state[2] = CharN;
         gen_state[3] = CharY;
      end
      for (i = 0; i < 8; i++) advance_state();
   endfunction

   function automatic void predict_beat(logic action, word_type seed);
      if (action == ActReseed) begin
         reseed_state(seed);
      end else begin
         advance_state();
         expected_values.push_back(tempered_value());
      end
   endfunction

   // mostly random waits, with occasional runs of back-to-back beats
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic word_type corner_word();
      case ($urandom_range(0, 3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= ReportLimit) $display("%0t: %s", $realtime, msg);
   endfunction

   function automatic void queue_request(logic action, word_type seed);
      request_beat_type beat;
      beat.action = action;
      beat.seed = seed;
      pending_requests.push_back(beat);
      queued_total++;
   endfunction

   // request driver; expectations are computed at each accepted beat
   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = ActNext;
      req_ch.seed = '0;
      rsp_ch.ready = 1'b0;
      for (int k = 0; k < 4; k++) gen_state[k] = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_beat(req_ch.action, req_ch.seed);
            accepted_total++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_req = pending_requests.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.action <= next_req.action;
               req_ch.seed <= next_req.seed;
               send_gap = draw_wait(send_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_values.size() == 0) begin
               flag_error($sformatf("unexpected beat, random_value %08h",
                                    rsp_ch.random_value));
            end else if (expected_values[0] !== rsp_ch.random_value) begin
               flag_error($sformatf("random_value mismatch: expected %08h got %08h",
                                    expected_values[0], rsp_ch.random_value));
               void'(expected_values.pop_front());
            end else begin
               void'(expected_values.pop_front());
            end
            recv_hold = draw_wait(recv_calm);
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input word_type value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CsrMaskA:  mask_a = value;
         CsrMaskB:  mask_b = value;
         CsrTemper: mask_t = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (accepted_total != queued_total || expected_values.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // pick masks and seed so that mixing lands on an all-zero state
   // (word 0 may keep only bit 31), forcing the TINY fallback
   task automatic queue_degenerate_seed(input word_type top_word);
      word_type mixed1, seed_word;
      mixed1 = mix_term(top_word, 32'd5);
      seed_word = top_word ^ mix_term(32'd7, 32'd4);
      write_csr(CsrMaskA, mixed1 ^ mix_term(seed_word, 32'd1));
      write_csr(CsrMaskB, 32'd6 ^ mix_term(mixed1, 32'd2));
      write_csr(CsrTemper, 32'd7 ^ mix_term(32'd6, 32'd3));
      queue_request(ActReseed, seed_word);
      repeat (3) queue_request(ActNext, $urandom());
      wait_drained();
   endtask

   task automatic queue_random_items(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 19) == 0)
            queue_request(ActReseed, ($urandom_range(0, 3) == 0) ? corner_word() : $urandom());
         else
            queue_request(ActNext, $urandom());
      end
   endtask

   initial begin
      word_type ma, mb, mt;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset masks; values before any reseed, corner seeds, back-to-back reseeds
      repeat (3) queue_request(ActNext, 32'h0000_0000);
      queue_request(ActReseed, 32'h0000_0000);
      repeat (2) queue_request(ActNext, 32'h0000_0000);
      queue_request(ActReseed, 32'hFFFF_FFFF);
      queue_request(ActNext, 32'hFFFF_FFFF);
      queue_request(ActReseed, 32'h8000_0000);
      queue_request(ActNext, 32'h8000_0000);
      queue_request(ActReseed, 32'h0000_0001);
      queue_request(ActReseed, 32'h7FFF_FFFF);
      repeat (2) queue_request(ActNext, $urandom());
      wait_drained();

      write_csr(CsrUnused, 32'hFFFF_FFFF);
      queue_degenerate_seed(32'h0000_0000);
      queue_degenerate_seed(32'h8000_0000);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin ma = '0; mb = '0; mt = '0; end
            1: begin ma = '1; mb = '1; mt = '1; end
            2: begin ma = MaskAReset; mb = MaskBReset; mt = TemperReset; end
            default: begin
               ma = ($urandom_range(0, 3) == 0) ? corner_word() : $urandom();
               mb = ($urandom_range(0, 3) == 0) ? corner_word() : $urandom();
               mt = ($urandom_range(0, 3) == 0) ? corner_word() : $urandom();
            end
         endcase
         write_csr(CsrMaskA, ma);
         write_csr(CsrMaskB, mb);
         write_csr(CsrTemper, mt);
         if (ph[0]) write_csr(CsrUnused, $urandom());
         queue_random_items(225);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("PASS tinymt32_generator");
      end else begin
         $display("FAIL tinymt32_generator");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL tinymt32_generator");
      $finish;
   end

endmodule
